// ===== rtl/neuron_mac_tanh_top_defines.svh =====
// assertion macros shared by the neuron mac rtl
`ifndef NEURON_MAC_TANH_TOP_DEFINES_SVH
`define NEURON_MAC_TANH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// consequent holds in the same cycle as the antecedent
`define NMT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds in the cycle after the antecedent
`define NMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NMT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define NMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/nmt_pkg.sv =====
// shared types, constants and table build functions for the neuron mac block
`default_nettype none

package nmt_pkg;

  // datapath widths and queue depth
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 32;
  localparam int FRAC_W      = 26;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [63:0]      Q30_ONE = 64'd1 << 30;

  // register map, indexed by paddr[2]
  localparam logic REG_INTERCEPT = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  // input request
  typedef struct packed {
    logic signed [15:0] input_value;
    logic signed [15:0] node_coefficient;
    logic               last_term;
  } in_req_t;

  // result
  typedef struct packed {
    logic signed [31:0] node_output;
    logic               saturated;
  } out_rsp_t;

  // queue entry between front and back
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     last;
  } mac_term_t;

  // configuration seen by the back end
  typedef struct packed {
    logic signed [31:0] intercept;
    logic               mode;
  } cfg_t;

  // restoring division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    int          b;
    rem = '0;
    q   = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh sample k of depth over [0, 4), unsigned q0.16
  function automatic logic [15:0] tanh_entry(input int unsigned k, input int unsigned depth);
    logic [63:0] z;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] y;
    int          j;
    int          s;
    z    = udiv64(64'(k) << 30, 64'(depth));
    term = Q30_ONE;
    h    = Q30_ONE;
    // taylor series of exp(z)
    for (j = 1; j < 40; j++) begin
      if (term != 64'd0) begin
        term = udiv64((term * z) >> 30, 64'(j));
        h    = h + term;
      end
    end
    // invert, then raise to the eighth power
    r = udiv64((64'd1 << 60) + (h >> 1), h);
    for (s = 0; s < 3; s++) begin
      r = (r * r) >> 30;
    end
    if (r > Q30_ONE) begin
      r = Q30_ONE;
    end
    num = (Q30_ONE - r) << 16;
    den = Q30_ONE + r;
    y   = udiv64(num + (den >> 1), den);
    if (y > 64'd65535) begin
      y = 64'd65535;
    end
    return y[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nmt_fifo.sv =====
// short request queue between the front and back ends
`default_nettype none
`include "neuron_mac_tanh_top_defines.svh"

module nmt_fifo import nmt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mac_term_t push_data,
  output logic      full,
  input  logic      pop,
  output mac_term_t head,
  output logic      empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mac_term_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  // status and head entry
  assign full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `NMT_ASSERT_SAME(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `NMT_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !empty, "pop from empty queue")
  `NMT_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "count did not grow")

endmodule

`default_nettype wire

// ===== rtl/nmt_front.sv =====
// front end: takes requests and forms the product term for the queue
`default_nettype none

module nmt_front import nmt_pkg::*; (
  input  logic      in_valid,
  output logic      in_stall,
  input  in_req_t   in_data,
  input  logic      full,
  output logic      push,
  output mac_term_t push_data
);

  // hold off the sender while the queue is full
  assign in_stall = full;
  assign push     = in_valid && !full;

  // exact q8.24 product of two q4.12 values, tagged with the last flag
  assign push_data.prod = PROD_W'($signed(in_data.input_value))
                        * PROD_W'($signed(in_data.node_coefficient));
  assign push_data.last = in_data.last_term;

endmodule

`default_nettype wire

// ===== rtl/nmt_back.sv =====
// back end: guarded accumulation and the activation sequencer
`default_nettype none
`include "neuron_mac_tanh_top_defines.svh"

module nmt_back import nmt_pkg::*; #(
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  mac_term_t term,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_rsp_t  out_data
);

  localparam int IDX_W = $clog2(TANH_TABLE_DEPTH);
  localparam int POS_W = FRAC_W + $clog2(TANH_TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TANH_TABLE_DEPTH - 1);
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TANH_TABLE_DEPTH);
  localparam logic [16:0]      ONE_Q16   = 17'h10000;

  typedef enum logic [2:0] {
    ST_ACC, ST_HALF, ST_MAG, ST_POS, ST_LOOK, ST_MULT, ST_DONE
  } state_t;

  state_t            state;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  half;
  logic              sat;
  logic [ACC_W-1:0]  mag;
  logic              neg;
  logic [POS_W-1:0]  pos;
  logic              big;
  logic [16:0]       t0;
  logic [16:0]       dlt;
  logic [FRAC_W-1:0] frac;
  logic [42:0]       interp;

  logic [15:0]       tanh_lut [TANH_TABLE_DEPTH];
  logic [ACC_W:0]    sum_ext;
  logic [ACC_W-1:0]  acc_next;
  logic [ACC_W:0]    scalar;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_up;
  logic [16:0]       t0_next;
  logic [16:0]       t1_next;
  logic [16:0]       y;
  logic [31:0]       mag_q24;
  logic [31:0]       tanh_res;
  logic              clip;
  logic [31:0]       id_res;
  out_rsp_t          result;

  // constant tanh table built at elaboration
  for (genvar k = 0; k < TANH_TABLE_DEPTH; k++) begin : g_lut
    localparam logic [15:0] ENTRY = tanh_entry(k, TANH_TABLE_DEPTH);
    assign tanh_lut[k] = ENTRY;
  end

  assign pop = (state == ST_ACC) && !empty;

  // saturating accumulate
  always_comb begin
    sum_ext = {acc[ACC_W-1], acc}
            + {{(ACC_W+1-PROD_W){term.prod[PROD_W-1]}}, term.prod};
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      acc_next = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum_ext[ACC_W-1:0];
    end
  end

  // intercept add, halved by the shift below
  assign scalar = {acc[ACC_W-1], acc}
                + {{(ACC_W+1-32){cfg.intercept[31]}}, cfg.intercept};

  // table lookup and slope
  always_comb begin
    idx     = pos[FRAC_W +: IDX_W];
    idx_up  = idx + 1'b1;
    t0_next = {1'b0, tanh_lut[idx]};
    t1_next = (idx == LAST_IDX) ? ONE_Q16 : {1'b0, tanh_lut[idx_up]};
    if (t1_next < t0_next) begin
      t1_next = t0_next;
    end
  end

  // final result forming
  always_comb begin
    y        = big ? ONE_Q16 : t0 + interp[42:FRAC_W];
    mag_q24  = {7'b0, y, 8'b0};
    tanh_res = neg ? (~mag_q24 + 32'd1) : mag_q24;
    clip     = !((&half[ACC_W-1:31]) || !(|half[ACC_W-1:31]));
    if (clip) begin
      id_res = half[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      id_res = half[31:0];
    end
    if (cfg.mode) begin
      result.node_output = tanh_res;
      result.saturated   = sat;
    end else begin
      result.node_output = id_res;
      result.saturated   = sat || clip;
    end
  end

  // sequencer, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (pop) begin
            acc <= acc_next;
            if (term.last) begin
              state <= ST_HALF;
            end
          end
        end
        ST_HALF: begin
          half  <= scalar[ACC_W:1];
          sat   <= (acc == ACC_MAX) || (acc == ACC_MIN);
          acc   <= '0;
          state <= ST_MAG;
        end
        ST_MAG: begin
          neg   <= half[ACC_W-1];
          mag   <= half[ACC_W-1] ? (~half + 1'b1) : half;
          state <= ST_POS;
        end
        ST_POS: begin
          big   <= |mag[ACC_W-1:FRAC_W];
          pos   <= POS_W'(mag[FRAC_W-1:0]) * DEPTH_POS;
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          t0    <= t0_next;
          dlt   <= t1_next - t0_next;
          frac  <= pos[FRAC_W-1:0];
          state <= ST_MULT;
        end
        ST_MULT: begin
          interp <= 43'(dlt) * 43'(frac);
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  `NMT_ASSERT_SAME(a_pop_only_acc, clk, rst, state != ST_ACC, !pop, "pop while finishing")
  `NMT_ASSERT_SAME(a_rise_from_done, clk, rst, $rose(out_valid), $past(state == ST_DONE), "result outside done")
  `NMT_ASSERT_NEXT(a_acc_cleared, clk, rst, state == ST_HALF, acc == '0, "accumulator not cleared")

endmodule

`default_nettype wire

// ===== rtl/neuron_mac_tanh_top.sv =====
// Top level of one neural-network node: streamed q4.12 dot product with tanh
// or identity activation.
// Input channel (in_valid / in_stall / in_data): one request per term, taken
// at an edge with in_valid high and in_stall low. The product enters a
// four-entry queue; in_stall rises only when that queue is full.
// The back end drains one non-last term per cycle, while it is accumulating
// and the queue is not empty, into a saturating 48-bit accumulator. A term
// marked last_term runs a finishing sequence of seven steps (accumulate,
// intercept and halving, magnitude, table position, lookup, interpolation
// multiply, output), so the back end takes no new term until the node is
// finished; new requests keep queueing meanwhile.
// Output channel (out_valid / out_stall / out_data): a result register holds
// the result while out_stall is high; the back end then waits in its output
// step and the queue fills behind it.
// Configuration: apb writes at 0 (intercept_q24) and 4 (activation_mode).
// Reset clears the queue, the accumulator and the output valid flag, sets the
// intercept to zero and selects tanh.
`default_nettype none

module neuron_mac_tanh_top import nmt_pkg::*; #(
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_rsp_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  logic      cfg_wr;
  logic      push;
  mac_term_t push_data;
  logic      full;
  logic      pop;
  mac_term_t head;
  logic      empty;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intercept <= '0;
      cfg.mode      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_INTERCEPT: cfg.intercept <= pwdata;
        REG_MODE:      cfg.mode      <= pwdata[0];
        default:       cfg.mode      <= cfg.mode;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_INTERCEPT: prdata = cfg.intercept;
      REG_MODE:      prdata = {31'b0, cfg.mode};
      default:       prdata = '0;
    endcase
  end

  nmt_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  nmt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  nmt_back #(
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .term      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
